@@ sv/bsf_pkg.sv @@
// Shared types and constants for the byte-stuffing framer with XOR check.
package bsf_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h24;
	localparam logic [7:0] ESC_BYTE  = 8'h2F;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// part bits of a job, emitted lowest first
	localparam int P_OPEN  = 0;
	localparam int P_ESC   = 1;
	localparam int P_DATA  = 2;
	localparam int P_CLOSE = 3;
	localparam int NPARTS  = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       frame_start;
		logic       frame_end;
		logic [7:0] header_seed;
		logic [7:0] trailer_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       frame_done;
		logic [7:0] check_value;
		logic       check_match;
	} out_item_t;

	// results caused by one accepted item
	typedef struct packed {
		logic [NPARTS-1:0] parts;
		logic [7:0]        data_byte;
		logic [7:0]        close_byte;
		logic              close_bv;
		logic [7:0]        check;
		logic              match;
	} job_t;

endpackage

@@ sv/bsf_front.sv @@
// Front end: tracks frame state and turns each item into a job of up to four results.
module bsf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              decode_mode,
	input  logic              accept,
	input  bsf_pkg::in_item_t item,
	output logic              push,
	output bsf_pkg::job_t     job
);
	import bsf_pkg::*;

	logic       esc_pend_q;
	logic [7:0] acc_q;
	logic       inside_q;

	logic       esc_pend_n;
	logic [7:0] acc_n;
	logic       inside_n;
	logic [7:0] acc0;
	logic [7:0] acc1;
	logic       special;

	always_comb begin
		job        = '0;
		esc_pend_n = esc_pend_q;
		acc_n      = acc_q;
		inside_n   = inside_q;
		acc0       = acc_q;
		acc1       = acc_q;
		special    = (item.in_byte == FLAG_BYTE) || (item.in_byte == ESC_BYTE);
		job.data_byte = item.in_byte;

		if (!item.frame_start && !inside_q) begin
			// item outside a frame: dropped
		end else if (!decode_mode) begin
			if (item.frame_start) begin
				acc0 = item.header_seed ^ FLAG_BYTE;
				job.parts[P_OPEN] = 1'b1;
				esc_pend_n = 1'b0;
			end
			if (special) begin
				acc0 = acc0 ^ ESC_BYTE;
				job.parts[P_ESC] = 1'b1;
			end
			acc1 = acc0 ^ item.in_byte;
			job.parts[P_DATA] = 1'b1;
			acc_n    = acc1;
			inside_n = 1'b1;
			if (item.frame_end) begin
				job.parts[P_CLOSE] = 1'b1;
				job.close_byte = FLAG_BYTE;
				job.close_bv   = 1'b1;
				job.check      = acc1 ^ FLAG_BYTE;
				job.match      = 1'b1;
			end
		end else if (item.frame_start) begin
			// opening item counts as the flag whatever its value
			acc1       = item.header_seed ^ item.in_byte;
			acc_n      = acc1;
			inside_n   = 1'b1;
			esc_pend_n = 1'b0;
			if (item.frame_end) begin
				job.parts[P_CLOSE] = 1'b1;
				job.check = acc1;
				job.match = (acc1 == item.trailer_in);
			end
		end else begin
			acc1  = acc_q ^ item.in_byte;
			acc_n = acc1;
			if (item.frame_end) begin
				job.parts[P_CLOSE] = 1'b1;
				job.close_bv   = esc_pend_q;
				job.close_byte = esc_pend_q ? ESC_BYTE : 8'h00;
				job.check      = acc1;
				job.match      = (acc1 == item.trailer_in);
			end else if (esc_pend_q) begin
				esc_pend_n = 1'b0;
				// lone escape passes through ahead of an ordinary byte
				job.parts[P_ESC]  = !special;
				job.parts[P_DATA] = 1'b1;
			end else if (item.in_byte == ESC_BYTE) begin
				esc_pend_n = 1'b1;
			end else begin
				job.parts[P_DATA] = 1'b1;
			end
		end

		if (job.parts[P_CLOSE]) begin
			acc_n      = '0;
			inside_n   = 1'b0;
			esc_pend_n = 1'b0;
		end
	end

	assign push = accept && (|job.parts);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pend_q <= 1'b0;
			acc_q      <= '0;
			inside_q   <= 1'b0;
		end else if (accept) begin
			esc_pend_q <= esc_pend_n;
			acc_q      <= acc_n;
			inside_q   <= inside_n;
		end
	end

endmodule

@@ sv/bsf_queue.sv @@
// Short job queue between the front and back ends.
module bsf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bsf_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output bsf_pkg::job_t head_job
);
	import bsf_pkg::*;

	job_t               mem_q [QDEPTH];
	logic [QAW-1:0]     wr_ptr_q;
	logic [QAW-1:0]     rd_ptr_q;
	logic [QCW-1:0]     count_q;

	assign full       = (count_q == QCW'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/bsf_back.sv @@
// Back end: walks the parts of the head job, one result per cycle while out_ready allows, into an output register.
module bsf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  bsf_pkg::job_t      head_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output bsf_pkg::out_item_t out_data
);
	import bsf_pkg::*;

	logic [NPARTS-1:0] done_q;
	logic [NPARTS-1:0] remaining;
	logic [NPARTS-1:0] sel;
	logic              last;
	logic              load;
	logic              out_valid_q;
	out_item_t         out_q;
	out_item_t         res;

	assign remaining = head_job.parts & ~done_q;
	assign sel       = remaining & (~remaining + 1'b1);
	assign last      = ((remaining & ~sel) == '0);
	assign load      = head_valid && (!out_valid_q || out_ready);
	assign pop       = load && last;

	always_comb begin
		res          = '0;
		res.run_last = last;
		priority case (1'b1)
			sel[P_OPEN]: begin
				res.out_byte   = FLAG_BYTE;
				res.byte_valid = 1'b1;
			end
			sel[P_ESC]: begin
				res.out_byte   = ESC_BYTE;
				res.byte_valid = 1'b1;
			end
			sel[P_DATA]: begin
				res.out_byte   = head_job.data_byte;
				res.byte_valid = 1'b1;
			end
			default: begin
				res.out_byte    = head_job.close_byte;
				res.byte_valid  = head_job.close_bv;
				res.frame_done  = 1'b1;
				res.check_value = head_job.check;
				res.check_match = head_job.match;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				done_q <= last ? '0 : (done_q | sel);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ sv/byte_stuffing_framer_xor_check.sv @@
// Byte-stuffing framer/deframer with XOR check (flag 0x24, escape 0x2F), top level.
// Takes one item per cycle whenever the four-entry job queue has room. Each item yields
// zero to four results; the back end sends one result per cycle, while out_ready allows,
// from a registered output, so the queue absorbs the extra bytes of stuffing, opening and
// closing flags before in_ready drops. An accepted item is written into the job queue and
// then into the output register before its first result appears. The
// decode_mode register is written through cfg_we/cfg_wdata and should only change
// while no results are outstanding.
module byte_stuffing_framer_xor_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  bsf_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bsf_pkg::out_item_t out_data
);
	import bsf_pkg::*;

	logic decode_mode_q;
	logic accept;
	logic push;
	logic pop;
	logic full;
	logic head_valid;
	job_t push_job;
	job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
		end else if (cfg_we) begin
			decode_mode_q <= cfg_wdata;
		end
	end

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	bsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.decode_mode(decode_mode_q),
		.accept     (accept),
		.item       (in_data),
		.push       (push),
		.job        (push_job)
	);

	bsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	bsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_job  (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> out_data.run_last)
		else $error("frame_done without run_last");

	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |-> out_data.frame_done && out_data.out_byte == 8'h00)
		else $error("status-only result outside frame end");

	a_check_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.frame_done |-> out_data.check_value == 8'h00
			&& !out_data.check_match)
		else $error("check fields set on a mid-frame result");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid && head_job.parts != '0)
		else $error("queue pop without a job");
`endif

endmodule
